// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dcc_pkg.sv
package dcc_pkg;

    // default table geometry
    localparam int DEF_MAX_MESSAGES = 8;
    localparam int DEF_MAX_BYTES    = 8;

    // register reset values
    localparam logic [7:0] SHORT_RESET    = 8'd140;
    localparam logic [7:0] LONG_RESET     = 8'd56;
    localparam logic [4:0] PREAMBLE_RESET = 5'd16;
    localparam logic [7:0] MASK_MSB       = 8'h80;

    // configuration port
    localparam int         APB_ADDR_W   = 4;
    localparam logic [1:0] REG_SHORT    = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_PREAMBLE = 2'd2;

    typedef enum logic [1:0] {
        REQ_EVENT = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_LEN   = 2'd2
    } req_kind_t;

    typedef enum logic [1:0] {
        PH_PREAMBLE  = 2'd0,
        PH_SEPARATOR = 2'd1,
        PH_DATA      = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] msg_slot;
        logic [2:0] byte_slot;
        logic [7:0] write_value;
    } req_t;

    typedef struct packed {
        logic       pin_level;
        logic [7:0] reload_value;
        logic       bit_sent;
        logic [1:0] phase;
    } res_t;

    typedef struct packed {
        logic [7:0] short_reload;
        logic [7:0] long_reload;
        logic [4:0] preamble_bits;
    } cfg_t;

endpackage

// File: src/dcc_req_if.sv
interface dcc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [2:0] msg_slot;
    logic [2:0] byte_slot;
    logic [7:0] write_value;

    modport source (output valid, output req_type, output msg_slot, output byte_slot,
                    output write_value, input ready);
    modport sink   (input valid, input req_type, input msg_slot, input byte_slot,
                    input write_value, output ready);
endinterface

// File: src/dcc_res_if.sv
interface dcc_res_if;
    logic       valid;
    logic       ready;
    logic       pin_level;
    logic [7:0] reload_value;
    logic       bit_sent;
    logic [1:0] phase;

    modport source (output valid, output pin_level, output reload_value, output bit_sent,
                    output phase, input ready);
    modport sink   (input valid, input pin_level, input reload_value, input bit_sent,
                    input phase, output ready);
endinterface

// File: src/dcc_ram.sv
module dcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dcc_msg_table.sv
module dcc_msg_table #(
    parameter int MAX_MESSAGES = 8,
    parameter int MAX_BYTES    = 8,
    localparam int MW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  dcc_pkg::req_t   item,
    input  logic            rd_en,
    input  logic [MW-1:0]   rd_msg,
    input  logic [3:0]      rd_byte,
    output logic [7:0]      rd_byte_data,
    output logic [3:0]      rd_len,
    output logic            clear_busy
);
    import dcc_pkg::*;

    localparam int DEPTH = MAX_MESSAGES * MAX_BYTES;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = IW + 4;

    logic [CW-1:0] clear_cnt_reg;
    logic [CW-1:0] clear_cnt_next;

    logic [SW-1:0] rd_sum;
    logic [SW-1:0] wr_sum;
    logic [8:0]    wr_msg_wide;
    logic          msg_in_range;
    logic          byte_in_range;

    logic          byte_we;
    logic [IW-1:0] byte_waddr;
    logic [7:0]    byte_wdata;
    logic          len_we;
    logic [MW-1:0] len_waddr;
    logic [3:0]    len_wdata;

    assign clear_busy     = (clear_cnt_reg != CW'(DEPTH));
    assign clear_cnt_next = clear_cnt_reg + CW'(1);

    // sweep both tables to zero after reset, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (clear_busy)
        begin
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    assign rd_sum = SW'(rd_msg) * SW'(MAX_BYTES) + SW'(rd_byte);
    assign wr_sum = SW'(item.msg_slot) * SW'(MAX_BYTES) + SW'(item.byte_slot);

    assign wr_msg_wide   = {6'd0, item.msg_slot};
    assign msg_in_range  = (wr_msg_wide < 9'(MAX_MESSAGES));
    assign byte_in_range = ({1'b0, item.byte_slot} < 4'(MAX_BYTES));

    always_comb
    begin
        if (clear_busy)
        begin
            byte_we    = 1'b1;
            byte_waddr = clear_cnt_reg[IW-1:0];
            byte_wdata = '0;
            len_we     = (clear_cnt_reg < CW'(MAX_MESSAGES));
            len_waddr  = clear_cnt_reg[MW-1:0];
            len_wdata  = '0;
        end
        else
        begin
            byte_we    = wr_en && (item.req_type == REQ_BYTE) && msg_in_range && byte_in_range;
            byte_waddr = wr_sum[IW-1:0];
            byte_wdata = item.write_value;
            len_we     = wr_en && (item.req_type == REQ_LEN) && msg_in_range;
            len_waddr  = wr_msg_wide[MW-1:0];
            // clamp long lengths to the row size
            len_wdata  = (item.write_value > 8'(MAX_BYTES)) ? 4'(MAX_BYTES)
                                                            : item.write_value[3:0];
        end
    end

    dcc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (byte_wdata),
        .re    (rd_en),
        .raddr (rd_sum[IW-1:0]),
        .rdata (rd_byte_data)
    );

    dcc_ram #(
        .WIDTH (4),
        .DEPTH (MAX_MESSAGES)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (rd_en),
        .raddr (rd_msg),
        .rdata (rd_len)
    );

endmodule

// File: src/dcc_bit_seq.sv
module dcc_bit_seq #(
    parameter int MAX_MESSAGES = 8,
    parameter int MAX_BYTES    = 8,
    localparam int MW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  dcc_pkg::cfg_t   cfg,
    input  logic [7:0]      rd_byte_data,
    input  logic [3:0]      rd_len,
    output logic [MW-1:0]   rd_msg,
    output logic [3:0]      rd_byte,
    output dcc_pkg::res_t   result
);
    import dcc_pkg::*;

    phase_t        phase_reg,         phase_next;
    logic [4:0]    preamble_left_reg, preamble_left_next;
    logic [MW-1:0] current_msg_reg,   current_msg_next;
    logic [3:0]    current_byte_reg,  current_byte_next;
    logic [7:0]    shift_byte_reg,    shift_byte_next;
    logic [7:0]    bit_mask_reg,      bit_mask_next;
    logic          second_half_reg,   second_half_next;
    logic          last_was_long_reg, last_was_long_next;

    logic          one_bit;
    logic [7:0]    mask_shift;
    logic [3:0]    byte_inc;
    logic [4:0]    left_dec;
    logic [4:0]    pre_load;
    logic [3:0]    eff_len;
    logic          byte_ok;
    logic [MW-1:0] msg_wrap;

    assign rd_msg  = current_msg_reg;
    assign rd_byte = current_byte_reg;

    assign mask_shift = bit_mask_reg >> 1;
    assign byte_inc   = current_byte_reg + 4'd1;
    assign left_dec   = ((preamble_left_reg == 5'd0) ? 5'd1 : preamble_left_reg) - 5'd1;
    assign pre_load   = (cfg.preamble_bits == 5'd0) ? 5'd1 : cfg.preamble_bits;
    assign eff_len    = (rd_len == 4'd0) ? 4'd1 : rd_len;
    assign byte_ok    = (current_byte_reg < 4'(MAX_BYTES));
    assign msg_wrap   = (current_msg_reg == MW'(MAX_MESSAGES - 1)) ? '0
                                                                   : current_msg_reg + MW'(1);

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        preamble_left_next = preamble_left_reg;
        current_msg_next   = current_msg_reg;
        current_byte_next  = current_byte_reg;
        shift_byte_next    = shift_byte_reg;
        bit_mask_next      = bit_mask_reg;
        last_was_long_next = last_was_long_reg;
        one_bit            = ~last_was_long_reg;
        if (second_half_reg)
        begin
            second_half_next = 1'b0;
        end
        else
        begin
            second_half_next = 1'b1;
            unique case (phase_reg)
                PH_SEPARATOR:
                begin
                    one_bit         = 1'b0;
                    phase_next      = PH_DATA;
                    shift_byte_next = byte_ok ? rd_byte_data : 8'd0;
                    bit_mask_next   = MASK_MSB;
                end
                PH_DATA:
                begin
                    one_bit       = |(shift_byte_reg & bit_mask_reg);
                    bit_mask_next = mask_shift;
                    if (mask_shift == 8'd0)
                    begin
                        current_byte_next = byte_inc;
                        if (byte_inc >= eff_len)
                        begin
                            phase_next         = PH_PREAMBLE;
                            preamble_left_next = pre_load;
                        end
                        else
                        begin
                            phase_next = PH_SEPARATOR;
                        end
                    end
                end
                default:
                begin
                    one_bit            = 1'b1;
                    phase_next         = PH_PREAMBLE;
                    preamble_left_next = left_dec;
                    if (left_dec == 5'd0)
                    begin
                        phase_next        = PH_SEPARATOR;
                        current_msg_next  = msg_wrap;
                        current_byte_next = 4'd0;
                    end
                end
            endcase
            last_was_long_next = ~one_bit;
        end
    end

    // result word
    always_comb
    begin
        result.pin_level    = second_half_reg;
        result.reload_value = one_bit ? cfg.short_reload : cfg.long_reload;
        result.bit_sent     = one_bit;
        result.phase        = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_PREAMBLE;
            preamble_left_reg <= PREAMBLE_RESET;
            current_msg_reg   <= '0;
            current_byte_reg  <= '0;
            shift_byte_reg    <= '0;
            bit_mask_reg      <= MASK_MSB;
            second_half_reg   <= 1'b0;
            last_was_long_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            preamble_left_reg <= preamble_left_next;
            current_msg_reg   <= current_msg_next;
            current_byte_reg  <= current_byte_next;
            shift_byte_reg    <= shift_byte_next;
            bit_mask_reg      <= bit_mask_next;
            second_half_reg   <= second_half_next;
            last_was_long_reg <= last_was_long_next;
        end
    end

endmodule

// File: src/dcc_packet_bit_generator.sv
// DCC packet bit generator. Each half-period event word on req yields one result word on res:
// the track pin level and the timer reload for the next half period. First halves drive the
// pin low and pick the next bit (preamble ones, a zero separator before each byte, then the
// byte MSB first); second halves drive it high and repeat the duration. Write words (byte or
// length) fill the message table and give no result. An event passes through the registered
// read of the message table, then the sequencer update into the output register, and only one
// event is in flight at a time; a write word lands in the table at its accept edge. A result
// waiting on res does not block the next word. After reset all MAX_MESSAGES*MAX_BYTES entries
// of the table (64 by default) are swept to zero, during which req.ready stays low; APB
// writes are taken throughout. Registers: 0x0 short_reload, 0x4 long_reload,
// 0x8 preamble_bits.
module dcc_packet_bit_generator #(
    parameter int MAX_MESSAGES = dcc_pkg::DEF_MAX_MESSAGES,
    parameter int MAX_BYTES    = dcc_pkg::DEF_MAX_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dcc_req_if.sink                       req,
    dcc_res_if.source                     res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import dcc_pkg::*;

    localparam int MW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;

    // configuration registers
    logic [7:0] short_reload_reg;
    logic [7:0] long_reload_reg;
    logic [4:0] preamble_bits_reg;
    logic       cfg_write;
    logic [1:0] reg_index;
    cfg_t       cfg;

    // pipeline control
    logic       s1_valid_reg,  s1_valid_next;
    logic       res_valid_reg, res_valid_next;
    res_t       res_data_reg;
    logic       in_accept;
    logic       event_accept;
    logic       s1_done;
    req_t       item;

    // table and sequencer wiring
    logic [MW-1:0] rd_msg;
    logic [3:0]    rd_byte;
    logic [7:0]    rd_byte_data;
    logic [3:0]    rd_len;
    logic          clear_busy;
    res_t          step_result;

    // APB: zero wait states, write on the access phase
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reload_reg  <= SHORT_RESET;
            long_reload_reg   <= LONG_RESET;
            preamble_bits_reg <= PREAMBLE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_SHORT:    short_reload_reg  <= pwdata[7:0];
                REG_LONG:     long_reload_reg   <= pwdata[7:0];
                REG_PREAMBLE: preamble_bits_reg <= pwdata[4:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_SHORT:    prdata = {24'd0, short_reload_reg};
            REG_LONG:     prdata = {24'd0, long_reload_reg};
            REG_PREAMBLE: prdata = {27'd0, preamble_bits_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.short_reload  = short_reload_reg;
    assign cfg.long_reload   = long_reload_reg;
    assign cfg.preamble_bits = preamble_bits_reg;

    // pack the request word
    assign item.req_type    = req.req_type;
    assign item.msg_slot    = req.msg_slot;
    assign item.byte_slot   = req.byte_slot;
    assign item.write_value = req.write_value;

    // Hold off new words while the sweep runs or an accepted event has not yet retired.
    // Writes land in the table at the accept edge, so an event that follows reads them.
    assign req.ready    = !clear_busy && !s1_valid_reg;
    assign in_accept    = req.valid && req.ready;
    assign event_accept = in_accept && (item.req_type == REQ_EVENT);

    // The event step retires once the output register is free or being drained.
    assign s1_done = s1_valid_reg && (!res_valid_reg || res.ready);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (event_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s1_done)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // output register payload, loaded when the step retires
    always_ff @(posedge clk)
    begin
        if (s1_done)
        begin
            res_data_reg <= step_result;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.pin_level    = res_data_reg.pin_level;
    assign res.reload_value = res_data_reg.reload_value;
    assign res.bit_sent     = res_data_reg.bit_sent;
    assign res.phase        = res_data_reg.phase;

    dcc_msg_table #(
        .MAX_MESSAGES (MAX_MESSAGES),
        .MAX_BYTES    (MAX_BYTES)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (in_accept),
        .item         (item),
        .rd_en        (event_accept),
        .rd_msg       (rd_msg),
        .rd_byte      (rd_byte),
        .rd_byte_data (rd_byte_data),
        .rd_len       (rd_len),
        .clear_busy   (clear_busy)
    );

    dcc_bit_seq #(
        .MAX_MESSAGES (MAX_MESSAGES),
        .MAX_BYTES    (MAX_BYTES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_done),
        .cfg          (cfg),
        .rd_byte_data (rd_byte_data),
        .rd_len       (rd_len),
        .rd_msg       (rd_msg),
        .rd_byte      (rd_byte),
        .result       (step_result)
    );

endmodule

// File: src/dcc_checker.sv
`include "assert_macros.svh"

module dcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_type,
    input logic       res_valid,
    input logic       res_ready,
    input logic       pin_level,
    input logic [7:0] reload_value,
    input logic       bit_sent,
    input logic [1:0] phase
);
    import dcc_pkg::*;

    logic event_acc;
    logic write_acc;
    logic res_stall;

    assign event_acc = req_valid && req_ready && (req_type == REQ_EVENT);
    assign write_acc = req_valid && req_ready &&
                       ((req_type == REQ_BYTE) || (req_type == REQ_LEN));
    assign res_stall = res_valid && !res_ready;

    // one event in flight: drop ready right after taking one
    `ASSERT_NEXT(a_event_interlock, clk, rst_n, event_acc, !req_ready, "ready high behind an event")
    // an event into an empty output shows its result once through the table read and output registers
    `ASSERT_NEXT(a_event_latency, clk, rst_n, $past(event_acc && !res_valid), res_valid, "event result late")
    // writes never produce a result word
    `ASSERT_NEXT(a_write_silent, clk, rst_n, write_acc && !res_valid, !res_valid, "write gave a result")
    // a stalled result word holds
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_stall,
        res_valid && $stable(pin_level) && $stable(reload_value) && $stable(bit_sent) &&
        $stable(phase), "result changed while stalled")

endmodule

bind dcc_packet_bit_generator dcc_checker u_dcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_type     (req.req_type),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .pin_level    (res.pin_level),
    .reload_value (res.reload_value),
    .bit_sent     (res.bit_sent),
    .phase        (res.phase)
);

// File: tb/dcc_packet_bit_generator_test.sv
`timescale 1ns / 100ps

module dcc_packet_bit_generator_test;
    import dcc_pkg::*;

    // Request code the block must drop without a result.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    // Hold-off before a register write: covers a table write still in flight.
    localparam int SETTLE_CYCLES = 4;
    // Cycles to keep watching for stray results once nothing is due.
    localparam int DRAIN_CYCLES = 20;
    // Cycles with no word moving on either channel before the run is declared hung.
    // Covers the table sweep after reset, receiver stalls and register updates.
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 9;
    localparam int WORDS_PER_PHASE = 100;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    // One row of the directed plan: either a request word or a register write.
    // Rows with 'typed' set carry the expected result spelled out by hand.
    typedef struct packed {
        row_kind_t  kind;
        req_t       w;
        logic [1:0] reg_idx;
        logic [7:0] reg_val;
        logic       typed;
        res_t       want;
    } plan_row_t;

    localparam req_t NO_REQ = '0;
    localparam res_t NO_RES = '0;

    localparam int PLAN_ROWS = 24;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // first and second half of the first preamble one, reset registers
        '{ROW_WORD, '{REQ_EVENT, 3'd0, 3'd0, 8'h00}, REG_SHORT, 8'h00, 1'b1,
          '{1'b0, SHORT_RESET, 1'b1, PH_PREAMBLE}},
        '{ROW_WORD, '{REQ_EVENT, 3'd0, 3'd0, 8'h00}, REG_SHORT, 8'h00, 1'b1,
          '{1'b1, SHORT_RESET, 1'b1, PH_PREAMBLE}},
        // unknown request: dropped, no result
        '{ROW_WORD, '{REQ_UNKNOWN, 3'd7, 3'd7, 8'hFF}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        // table byte writes, two of them at the corners of the table
        '{ROW_WORD, '{REQ_BYTE, 3'd0, 3'd0, 8'h00}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_BYTE, 3'd7, 3'd7, 8'hFF}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_BYTE, 3'd1, 3'd0, 8'hA5}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_BYTE, 3'd1, 3'd1, 8'h5A}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        // lengths: normal, clamped from above, zero, exactly full, one past full
        '{ROW_WORD, '{REQ_LEN, 3'd1, 3'd0, 8'd2}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_LEN, 3'd2, 3'd5, 8'd255}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_LEN, 3'd3, 3'd0, 8'd0}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_LEN, 3'd7, 3'd7, 8'd8}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_LEN, 3'd0, 3'd2, 8'd9}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        // register extremes, including a zero preamble count
        '{ROW_REG, NO_REQ, REG_SHORT, 8'hFF, 1'b0, NO_RES},
        '{ROW_REG, NO_REQ, REG_LONG, 8'h00, 1'b0, NO_RES},
        '{ROW_REG, NO_REQ, REG_PREAMBLE, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_EVENT, 3'd7, 3'd7, 8'hFF}, REG_SHORT, 8'h00, 1'b1,
          '{1'b0, 8'hFF, 1'b1, PH_PREAMBLE}},
        '{ROW_WORD, '{REQ_EVENT, 3'd7, 3'd7, 8'hFF}, REG_SHORT, 8'h00, 1'b1,
          '{1'b1, 8'hFF, 1'b1, PH_PREAMBLE}},
        '{ROW_REG, NO_REQ, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_REG, NO_REQ, REG_LONG, 8'hFF, 1'b0, NO_RES},
        '{ROW_REG, NO_REQ, REG_PREAMBLE, 8'h1F, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_EVENT, 3'd3, 3'd4, 8'h81}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_EVENT, 3'd4, 3'd3, 8'h7E}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_BYTE, 3'd0, 3'd7, 8'h80}, REG_SHORT, 8'h00, 1'b0, NO_RES},
        '{ROW_WORD, '{REQ_EVENT, 3'd0, 3'd0, 8'h00}, REG_SHORT, 8'h00, 1'b0, NO_RES}
    };

    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    dcc_req_if req_bus ();
    dcc_res_if res_bus ();

    dcc_packet_bit_generator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .res     (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Track signal predictor: a private copy of the message table, the
    // bit sequencer and the register file.
    // ---------------------------------------------------------------
    cfg_t       cfg_now;
    logic [7:0] tab_bytes [DEF_MAX_MESSAGES*DEF_MAX_BYTES];
    logic [3:0] tab_len [DEF_MAX_MESSAGES];
    phase_t     line_phase;
    logic [4:0] pre_left;
    logic [2:0] cur_msg;
    logic [3:0] cur_byte;
    logic [7:0] shift_q;
    logic [7:0] mask_q;
    logic       second_q;
    logic       last_long_q;

    res_t half_periods_due [$];   // results owed by the block, oldest first
    int   bad_words;
    int   stall_cycles;
    bit   steady;                 // suppress idling on both channels
    bit   fixed_on;               // current word carries a hand-typed expectation
    res_t fixed_res;

    // Advance the predictor by one accepted request word. Return 1 and the
    // result when the word is a half-period event, else update the table for a write word.
    function automatic bit track_step(input req_t w, output res_t r);
        logic       one;
        logic [3:0] eff_len;
        r = '0;
        case (w.req_type)
            REQ_BYTE:
            begin
                tab_bytes[w.msg_slot*DEF_MAX_BYTES + w.byte_slot] = w.write_value;
                return 1'b0;
            end
            REQ_LEN:
            begin
                // clamp long lengths to a full message
                tab_len[w.msg_slot] = (w.write_value > DEF_MAX_BYTES) ?
                                      4'(DEF_MAX_BYTES) : w.write_value[3:0];
                return 1'b0;
            end
            REQ_EVENT: ;
            default: return 1'b0;
        endcase

        if (second_q)
        begin
            // second half: repeat the duration of the first half
            second_q = 1'b0;
            one = ~last_long_q;
            r.pin_level = 1'b1;
        end
        else
        begin
            second_q = 1'b1;
            r.pin_level = 1'b0;
            case (line_phase)
                PH_SEPARATOR:
                begin
                    one = 1'b0;
                    line_phase = PH_DATA;
                    shift_q = (cur_byte < DEF_MAX_BYTES) ?
                              tab_bytes[cur_msg*DEF_MAX_BYTES + cur_byte] : 8'h00;
                    mask_q = MASK_MSB;
                end
                PH_DATA:
                begin
                    one = |(shift_q & mask_q);
                    mask_q = mask_q >> 1;
                    if (mask_q == 8'h00)
                    begin
                        cur_byte = cur_byte + 4'd1;
                        // zero length acts as a one-byte message
                        eff_len = (tab_len[cur_msg] == 4'd0) ? 4'd1 : tab_len[cur_msg];
                        if (cur_byte >= eff_len)
                        begin
                            line_phase = PH_PREAMBLE;
                            pre_left = (cfg_now.preamble_bits == 5'd0) ?
                                       5'd1 : cfg_now.preamble_bits;
                        end
                        else
                            line_phase = PH_SEPARATOR;
                    end
                end
                default:
                begin
                    one = 1'b1;
                    line_phase = PH_PREAMBLE;
                    if (pre_left == 5'd0)
                        pre_left = 5'd1;
                    pre_left = pre_left - 5'd1;
                    if (pre_left == 5'd0)
                    begin
                        // preamble done: advance to the next slot, wrapping
                        line_phase = PH_SEPARATOR;
                        cur_msg = cur_msg + 3'd1;
                        cur_byte = 4'd0;
                    end
                end
            endcase
            last_long_q = ~one;
        end
        r.reload_value = one ? cfg_now.short_reload : cfg_now.long_reload;
        r.bit_sent = one;
        r.phase = line_phase;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Sample both channels at the rising edge: check each result word
    // against the oldest expectation, then predict from each request word.
    // Count cycles where no word moves and abort on a hang.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        req_t w;
        res_t got;
        res_t want;
        res_t guess;
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                got = '{res_bus.pin_level, res_bus.reload_value, res_bus.bit_sent,
                        res_bus.phase};
                if (half_periods_due.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= MAX_REPORTS)
                        $display("unexpected result: pin %0b reload %0d bit %0b phase %0d",
                                 got.pin_level, got.reload_value, got.bit_sent, got.phase);
                end
                else
                begin
                    want = half_periods_due.pop_front();
                    if (got.pin_level !== want.pin_level ||
                        got.reload_value !== want.reload_value ||
                        got.bit_sent !== want.bit_sent || got.phase !== want.phase)
                    begin
                        bad_words++;
                        if (bad_words <= MAX_REPORTS)
                            $display(
                                "result differs: want %0b %0d %0b %0d, got %0b %0d %0b %0d",
                                want.pin_level, want.reload_value, want.bit_sent,
                                want.phase, got.pin_level, got.reload_value,
                                got.bit_sent, got.phase);
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                w = '{req_bus.req_type, req_bus.msg_slot, req_bus.byte_slot,
                      req_bus.write_value};
                if (track_step(w, guess))
                    half_periods_due.push_back(fixed_on ? fixed_res : guess);
            end
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("dcc_packet_bit_generator: mismatch");
                $finish;
            end
        end
    end

    // Receiver: drop ready at random, 17 percent of the time, unless running steady.
    always @(negedge clk)
        res_bus.ready <= steady || ($urandom_range(99) >= 17);

    // Offer one request word at the falling edge, idling at random first,
    // and hold it until accepted.
    task automatic send_word(input req_t w, input bit typed, input res_t want);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 17)
        begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.valid = 1'b1;
        req_bus.req_type = w.req_type;
        req_bus.msg_slot = w.msg_slot;
        req_bus.byte_slot = w.byte_slot;
        req_bus.write_value = w.write_value;
        fixed_on = typed;
        fixed_res = want;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    // Drop valid, drain every owed result, let trailing table writes settle,
    // then write one register over APB (setup, then access).
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (half_periods_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {24'h0, val};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SHORT: cfg_now.short_reload = val;
            REG_LONG: cfg_now.long_reload = val;
            REG_PREAMBLE: cfg_now.preamble_bits = val[4:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Draw one random request word: mostly half-period events, with table
    // writes mixed in to keep the stored messages changing, and rare unknown requests.
    function automatic req_t random_word();
        req_t w;
        int   pick;
        w.msg_slot = 3'($urandom_range(7));
        w.byte_slot = 3'($urandom_range(7));
        w.write_value = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 78)
            w.req_type = REQ_EVENT;
        else if (pick < 88)
            w.req_type = REQ_BYTE;
        else if (pick < 97)
        begin
            w.req_type = REQ_LEN;
            // keep most messages short so many of them complete
            if ($urandom_range(3) != 0)
                w.write_value = 8'($urandom_range(3));
        end
        else
            w.req_type = REQ_UNKNOWN;
        return w;
    endfunction

    initial
    begin : stimulus
        req_t w;
        int   counted;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_EVENT;
        req_bus.msg_slot = '0;
        req_bus.byte_slot = '0;
        req_bus.write_value = '0;
        res_bus.ready = 1'b0;
        bad_words = 0;
        stall_cycles = 0;
        steady = 1'b0;
        fixed_on = 1'b0;
        fixed_res = '0;

        // predictor state after reset
        cfg_now = '{SHORT_RESET, LONG_RESET, PREAMBLE_RESET};
        foreach (tab_bytes[i])
            tab_bytes[i] = 8'h00;
        foreach (tab_len[i])
            tab_len[i] = 4'd0;
        line_phase = PH_PREAMBLE;
        pre_left = PREAMBLE_RESET;
        cur_msg = 3'd0;
        cur_byte = 4'd0;
        shift_q = 8'h00;
        mask_q = MASK_MSB;
        second_q = 1'b0;
        last_long_q = 1'b0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed plan: walk the table row by row.
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_REG)
                write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
            else
                send_word(PLAN[i].w, PLAN[i].typed, PLAN[i].want);
        end

        // Random phases: fresh register settings each phase, extremes first.
        // One phase runs with no idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_SHORT, 8'h00);
                    write_reg(REG_LONG, 8'hFF);
                    write_reg(REG_PREAMBLE, 8'd1);
                end
                1:
                begin
                    write_reg(REG_SHORT, 8'hFF);
                    write_reg(REG_LONG, 8'h00);
                    write_reg(REG_PREAMBLE, 8'd31);
                end
                default:
                begin
                    write_reg(REG_SHORT, 8'($urandom_range(255)));
                    write_reg(REG_LONG, 8'($urandom_range(255)));
                    write_reg(REG_PREAMBLE, (p == 2) ? 8'd0 : 8'($urandom_range(4)));
                end
            endcase
            steady = (p == 5);
            counted = 0;
            while (counted < WORDS_PER_PHASE)
            begin
                w = random_word();
                send_word(w, 1'b0, NO_RES);
                // dropped requests do not count toward the phase
                if (w.req_type != REQ_UNKNOWN)
                    counted++;
            end
            steady = 1'b0;
        end

        // Drain: wait for every owed result, then watch for strays.
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (half_periods_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_words == 0)
            $display("dcc_packet_bit_generator: match");
        else
            $display("dcc_packet_bit_generator: mismatch");
        $finish;
    end

endmodule
